>>> rtl/ecc7264_pkg.sv
// ----------------------------------------------------------------------------
// ecc7264_pkg
// Check masks, syndrome decode table and result types for the 72/64 SECDED
// check-and-correct block.
// ----------------------------------------------------------------------------
package ecc7264_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned CHECK_W = 8;
	localparam int unsigned POS_W   = 7;

	localparam logic [7:0] SYN_OK = 8'hFF;
	localparam logic [7:0] SYN_XX = 8'hFE;
	localparam logic [7:0] K0 = 8'd64;
	localparam logic [7:0] K1 = 8'd65;
	localparam logic [7:0] K2 = 8'd66;
	localparam logic [7:0] K3 = 8'd67;
	localparam logic [7:0] K4 = 8'd68;
	localparam logic [7:0] K5 = 8'd69;
	localparam logic [7:0] K6 = 8'd70;
	localparam logic [7:0] K7 = 8'd71;
	localparam logic [7:0] XX = SYN_XX;

	typedef enum logic [1:0] {
		ST_CLEAN     = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_UNCORR    = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic [CHECK_W-1:0] check;
		status_t            status;
		logic [POS_W-1:0]   position;
	} ecc_result_t;

	localparam logic [DATA_W-1:0] CHECK_MASKS [CHECK_W] = '{
		64'h0000e8423c0f99ff, 64'h00e8423c0f99ff00,
		64'he8423c0f99ff0000, 64'h423c0f99ff0000e8,
		64'h3c0f99ff0000e842, 64'h0f99ff0000e8423c,
		64'h99ff0000e8423c0f, 64'hff0000e8423c0f99
	};

	localparam logic [7:0] SYN_DECODE [256] = '{
		SYN_OK, K0, K1, XX, K2, XX, XX, 8'd47, K3, XX, XX, 8'd37, XX, 8'd35, 8'd39, XX,
		K4, XX, XX, 8'd48, XX, 8'd30, 8'd29, XX, XX, 8'd57, 8'd27, XX, 8'd31, XX, XX, XX,
		K5, XX, XX, 8'd17, XX, 8'd18, 8'd40, XX, XX, 8'd58, 8'd22, XX, 8'd21, XX, XX, XX,
		XX, 8'd16, 8'd49, XX, 8'd19, XX, XX, XX, 8'd23, XX, XX, XX, XX, 8'd20, XX, XX,
		K6, XX, XX, 8'd51, XX, 8'd46, 8'd9, XX, XX, 8'd34, 8'd10, XX, 8'd32, XX, XX, 8'd36,
		XX, 8'd62, 8'd50, XX, 8'd14, XX, XX, XX, 8'd13, XX, XX, XX, XX, XX, XX, XX,
		XX, 8'd61, 8'd8, XX, 8'd41, XX, XX, XX, 8'd11, XX, XX, XX, XX, XX, XX, XX,
		8'd15, XX, XX, XX, XX, XX, XX, XX, XX, XX, 8'd12, XX, XX, XX, XX, XX,
		K7, XX, XX, 8'd55, XX, 8'd45, 8'd43, XX, XX, 8'd56, 8'd38, XX, 8'd1, XX, XX, XX,
		XX, 8'd25, 8'd26, XX, 8'd2, XX, XX, XX, 8'd24, XX, XX, XX, XX, XX, 8'd28, XX,
		XX, 8'd59, 8'd54, XX, 8'd42, XX, XX, 8'd44, 8'd6, XX, XX, XX, XX, XX, XX, XX,
		8'd5, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX,
		XX, 8'd63, 8'd53, XX, 8'd0, XX, XX, XX, 8'd33, XX, XX, XX, XX, XX, XX, XX,
		8'd3, XX, XX, 8'd52, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX,
		8'd7, XX, XX, XX, XX, XX, XX, XX, XX, 8'd60, XX, XX, XX, XX, XX, XX,
		XX, XX, XX, XX, 8'd4, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX, XX
	};

endpackage

>>> rtl/ecc7264_decode.sv
// ----------------------------------------------------------------------------
// ecc7264_decode
// Syndrome generation, table decode and single-bit correction for one
// 72-bit codeword. Purely combinational.
// ----------------------------------------------------------------------------
module ecc7264_decode (
	input  logic [ecc7264_pkg::DATA_W-1:0]  data_word,
	input  logic [ecc7264_pkg::CHECK_W-1:0] check_byte,
	output ecc7264_pkg::ecc_result_t        result
);
	import ecc7264_pkg::*;

	logic [CHECK_W-1:0] syndrome;
	logic [7:0]         pos;

	always_comb begin
		for (int k = 0; k < CHECK_W; k++) begin
			syndrome[k] = (^(data_word & CHECK_MASKS[k])) ^ check_byte[k];
		end
	end

	assign pos = SYN_DECODE[syndrome];

	always_comb begin
		result.data     = data_word;
		result.check    = check_byte;
		result.status   = ST_CORRECTED;
		result.position = pos[POS_W-1:0];
		if (pos == SYN_OK) begin
			result.status   = ST_CLEAN;
			result.position = '0;
		end else if (pos == SYN_XX) begin
			result.status   = ST_UNCORR;
			result.position = '0;
		end else if (pos[7:6] == 2'b00) begin
			result.data = data_word ^ (64'h1 << (6'd63 - pos[5:0]));
		end else begin
			result.check = check_byte ^ (8'h1 << pos[2:0]);
		end
	end

endmodule

>>> rtl/ecc_72_64_check_and_correct.sv
// ----------------------------------------------------------------------------
// ecc_72_64_check_and_correct
// SECDED check and correct for 64 data bits plus an 8-bit check byte.
// Path from accepted item beat to result beat: input register, decode, result
// register. Throughput: one beat per cycle while result_stall does not hold the result.
// Reset clears both stage valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module ecc_72_64_check_and_correct (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [ecc7264_pkg::DATA_W-1:0]  data_word,
	input  logic [ecc7264_pkg::CHECK_W-1:0] check_byte,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [ecc7264_pkg::DATA_W-1:0]  fixed_data,
	output logic [ecc7264_pkg::CHECK_W-1:0] fixed_check,
	output logic [1:0]                      word_status,
	output logic [ecc7264_pkg::POS_W-1:0]   error_position
);
	import ecc7264_pkg::*;

	logic               valid_s1;
	logic [DATA_W-1:0]  data_s1;
	logic [CHECK_W-1:0] check_s1;
	logic               valid_s2;
	ecc_result_t        result_s2;
	ecc_result_t        decoded;
	logic               accept;
	logic               advance;

	assign advance    = valid_s1 && !(valid_s2 && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_word;
			check_s1 <= check_byte;
		end
		if (advance) begin
			result_s2 <= decoded;
		end
	end

	ecc7264_decode u_decode (
		.data_word  (data_s1),
		.check_byte (check_s1),
		.result     (decoded)
	);

	assign result_valid   = valid_s2;
	assign fixed_data     = result_s2.data;
	assign fixed_check    = result_s2.check;
	assign word_status    = result_s2.status;
	assign error_position = result_s2.position;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives 72/64 SECDED codewords (clean, single-bit flips at directed and random positions,
// double and multi-bit damage, raw check bytes) into the check-and-correct
// block with random gaps and back-pressure. Each result beat is compared
// field by field against an independent syndrome decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import ecc7264_pkg::*;

	localparam logic [7:0] CLN = 8'hFF;
	localparam logic [7:0] BAD = 8'hFE;
	localparam logic [7:0] C0 = 8'd64;
	localparam logic [7:0] C1 = 8'd65;
	localparam logic [7:0] C2 = 8'd66;
	localparam logic [7:0] C3 = 8'd67;
	localparam logic [7:0] C4 = 8'd68;
	localparam logic [7:0] C5 = 8'd69;
	localparam logic [7:0] C6 = 8'd70;
	localparam logic [7:0] C7 = 8'd71;
	localparam int LAST_POS = 71;

	localparam logic [63:0] PARITY_MASK [8] = '{
		64'h0000e8423c0f99ff, 64'h00e8423c0f99ff00,
		64'he8423c0f99ff0000, 64'h423c0f99ff0000e8,
		64'h3c0f99ff0000e842, 64'h0f99ff0000e8423c,
		64'h99ff0000e8423c0f, 64'hff0000e8423c0f99
	};

	localparam logic [7:0] SYNDROME_POS [256] = '{
		CLN, C0, C1, BAD, C2, BAD, BAD, 47, C3, BAD, BAD, 37, BAD, 35, 39, BAD,
		C4, BAD, BAD, 48, BAD, 30, 29, BAD, BAD, 57, 27, BAD, 31, BAD, BAD, BAD,
		C5, BAD, BAD, 17, BAD, 18, 40, BAD, BAD, 58, 22, BAD, 21, BAD, BAD, BAD,
		BAD, 16, 49, BAD, 19, BAD, BAD, BAD, 23, BAD, BAD, BAD, BAD, 20, BAD, BAD,
		C6, BAD, BAD, 51, BAD, 46, 9, BAD, BAD, 34, 10, BAD, 32, BAD, BAD, 36,
		BAD, 62, 50, BAD, 14, BAD, BAD, BAD, 13, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		BAD, 61, 8, BAD, 41, BAD, BAD, BAD, 11, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		15, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, 12, BAD, BAD, BAD, BAD, BAD,
		C7, BAD, BAD, 55, BAD, 45, 43, BAD, BAD, 56, 38, BAD, 1, BAD, BAD, BAD,
		BAD, 25, 26, BAD, 2, BAD, BAD, BAD, 24, BAD, BAD, BAD, BAD, BAD, 28, BAD,
		BAD, 59, 54, BAD, 42, BAD, BAD, 44, 6, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		5, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		BAD, 63, 53, BAD, 0, BAD, BAD, BAD, 33, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		3, BAD, BAD, 52, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD,
		7, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, 60, BAD, BAD, BAD, BAD, BAD, BAD,
		BAD, BAD, BAD, BAD, 4, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD, BAD
	};

	typedef struct packed {
		logic [63:0] data;
		logic [7:0]  check;
		status_t     status;
		logic [6:0]  position;
	} fix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [63:0] data_word = '0;
	logic [7:0]  check_byte = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [63:0] fixed_data;
	logic [7:0]  fixed_check;
	logic [1:0]  word_status;
	logic [6:0]  error_position;

	logic [71:0] words_to_send [$];
	fix_t        fixes_due [$];
	int          failures = 0;
	int          n_clean = 0;
	int          n_fixed = 0;
	int          n_uncorr = 0;
	int          send_gap = 0;
	int          send_quiet = 0;
	int          stall_left = 0;
	int          recv_quiet = 0;

	ecc_72_64_check_and_correct dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_word      (data_word),
		.check_byte     (check_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.fixed_data     (fixed_data),
		.fixed_check    (fixed_check),
		.word_status    (word_status),
		.error_position (error_position)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [71:0] encode_word(logic [63:0] d);
		logic [7:0] c;
		for (int k = 0; k < 8; k++)
			c[k] = ^(d & PARITY_MASK[k]);
		return {d, c};
	endfunction

	// position p < 64 is data bit 63-p; position 64+k is check bit k
	function automatic logic [71:0] flip_pos(logic [71:0] cw, int pos);
		if (pos < 64)
			cw[71 - pos] = ~cw[71 - pos];
		else
			cw[pos - 64] = ~cw[pos - 64];
		return cw;
	endfunction

	function automatic fix_t correct_word(logic [63:0] d, logic [7:0] c);
		fix_t        r;
		logic [7:0]  syn;
		logic [7:0]  pos;
		logic [71:0] cw;
		cw = encode_word(d);
		syn = cw[7:0] ^ c;
		pos = SYNDROME_POS[syn];
		r.data = d;
		r.check = c;
		r.status = ST_CLEAN;
		r.position = '0;
		if (pos == BAD) begin
			r.status = ST_UNCORR;
		end else if (pos != CLN) begin
			r.status = ST_CORRECTED;
			r.position = pos[6:0];
			cw = flip_pos({d, c}, int'(pos));
			r.data = cw[71:8];
			r.check = cw[7:0];
		end
		return r;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic wait_drained();
		while (words_to_send.size() != 0 || item_valid || fixes_due.size() != 0)
			@(posedge clk);
	endtask

	// item side: hold the beat while stalled, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			data_word <= '0;
			check_byte <= '0;
			send_gap <= 0;
			send_quiet <= 0;
		end else begin
			if (item_valid && !item_stall)
				fixes_due.push_back(correct_word(data_word, check_byte));
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (words_to_send.size() != 0) begin
					item_valid <= 1'b1;
					{data_word, check_byte} <= words_to_send.pop_front();
					if (send_quiet > 0) begin
						send_quiet <= send_quiet - 1;
						send_gap <= 0;
					end else begin
						send_gap <= pause_len();
						if ($urandom_range(0, 49) == 0)
							send_quiet <= $urandom_range(20, 60);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin : result_side
		fix_t exp;
		int   hold;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			recv_quiet <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (fixes_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected result beat: data %h check %h status %0d",
						$time, fixed_data, fixed_check, word_status);
				end else begin
					exp = fixes_due.pop_front();
					case (exp.status)
						ST_CLEAN:     n_clean++;
						ST_CORRECTED: n_fixed++;
						default:      n_uncorr++;
					endcase
					if (fixed_data !== exp.data) begin
						failures++;
						$display("%0t: fixed_data expected %h actual %h",
							$time, exp.data, fixed_data);
					end
					if (fixed_check !== exp.check) begin
						failures++;
						$display("%0t: fixed_check expected %h actual %h",
							$time, exp.check, fixed_check);
					end
					if (word_status !== exp.status) begin
						failures++;
						$display("%0t: word_status expected %0d actual %0d",
							$time, exp.status, word_status);
					end
					if (error_position !== exp.position) begin
						failures++;
						$display("%0t: error_position expected %0d actual %0d",
							$time, exp.position, error_position);
					end
				end
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (recv_quiet > 0) begin
				result_stall <= 1'b0;
				recv_quiet <= recv_quiet - 1;
			end else begin
				hold = pause_len();
				result_stall <= (hold != 0);
				stall_left <= (hold != 0) ? hold - 1 : 0;
				if ($urandom_range(0, 49) == 0)
					recv_quiet <= $urandom_range(20, 60);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [71:0] cw;
		logic [63:0] d;
		int          kind;
		int          p;
		int          q;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		words_to_send.push_back(encode_word('0));
		words_to_send.push_back(encode_word('1));
		words_to_send.push_back({64'h0, 8'hFF});
		words_to_send.push_back({64'hFFFF_FFFF_FFFF_FFFF, 8'h00});
		words_to_send.push_back(flip_pos(encode_word('0), 0));
		words_to_send.push_back(flip_pos(encode_word('1), 63));
		words_to_send.push_back(flip_pos(encode_word(64'h0123_4567_89AB_CDEF), 64));
		words_to_send.push_back(flip_pos(encode_word(64'hFEDC_BA98_7654_3210), LAST_POS));
		words_to_send.push_back(flip_pos(encode_word(64'hAAAA_AAAA_AAAA_AAAA), 31));
		words_to_send.push_back(flip_pos(encode_word(64'h5555_5555_5555_5555), 32));
		words_to_send.push_back(flip_pos(encode_word('1), 68));
		words_to_send.push_back(flip_pos(flip_pos(encode_word('0), 0), LAST_POS));
		words_to_send.push_back(flip_pos(flip_pos(encode_word('1), 5), 6));
		words_to_send.push_back(flip_pos(flip_pos(encode_word(64'hDEAD_BEEF_0000_FFFF),
			40), 66));
		words_to_send.push_back(flip_pos(flip_pos(flip_pos(encode_word('0), 1), 2), 3));
		words_to_send.push_back({64'h8000_0000_0000_0001, 8'h80});
		words_to_send.push_back({64'h7FFF_FFFF_FFFF_FFFE, 8'h01});
		wait_drained();

		for (int i = 0; i < 850; i++) begin
			// hold off once mid-run until every result is back
			if (i == 425)
				wait_drained();
			d = {$urandom(), $urandom()};
			if ($urandom_range(0, 19) == 0)
				d = $urandom_range(0, 1) ? '1 : '0;
			cw = encode_word(d);
			kind = $urandom_range(0, 99);
			p = $urandom_range(0, LAST_POS);
			if (kind < 30) begin
				words_to_send.push_back(cw);
			end else if (kind < 65) begin
				words_to_send.push_back(flip_pos(cw, p));
			end else if (kind < 80) begin
				q = (p + $urandom_range(1, LAST_POS)) % (LAST_POS + 1);
				words_to_send.push_back(flip_pos(flip_pos(cw, p), q));
			end else begin
				words_to_send.push_back({d, 8'($urandom_range(0, 255))});
			end
			if (words_to_send.size() > 32)
				while (words_to_send.size() > 8)
					@(posedge clk);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d codewords checked: %0d clean, %0d single-bit corrected, %0d uncorrectable",
			n_clean + n_fixed + n_uncorr, n_clean, n_fixed, n_uncorr);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> ecc_72_64_check_and_correct.f
rtl/ecc7264_pkg.sv
rtl/ecc7264_decode.sv
rtl/ecc_72_64_check_and_correct.sv
bench/testbench.sv
